// ===== design/rvbp_pkg.sv =====
package rvbp_pkg;

  // Field and port widths fixed by the interface
  localparam int SRC_IDX_W  = 20;
  localparam int SIZE_W     = 11;
  localparam int PLACE_W    = 12;
  localparam int ID_W       = 8;
  localparam int ADDR_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Datapath widths
  localparam int COORD_W    = 14;                    // signed x/z after rotation and offset
  localparam int Y_W        = SRC_IDX_W + 1;         // y plus offset
  localparam int REM_W      = SIZE_W + 1;            // divider partial remainder
  localparam int DIV_BITS   = 2;                     // quotient bits per cycle
  localparam int DIV_CYCLES = SRC_IDX_W / DIV_BITS;
  localparam int STEP_W     = $clog2(DIV_CYCLES);

  // Storage depths
  localparam int CELL_DEPTH  = 2 ** ADDR_W;
  localparam int TABLE_DEPTH = 2 ** ID_W;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_PLACE = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OOB      = 2'd1,
    ST_OCCUPIED = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIENTATION = 3'd0,
    CFG_SRC_WIDTH   = 3'd1,
    CFG_SRC_LENGTH  = 3'd2,
    CFG_PLACE_X     = 3'd3,
    CFG_PLACE_Y     = 3'd4,
    CFG_PLACE_Z     = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ROT_NONE  = 2'd0,
    ROT_ONE   = 2'd1,
    ROT_TWO   = 2'd2,
    ROT_THREE = 2'd3
  } rot_e;

  typedef enum logic [1:0] {
    JOB_LOAD,
    JOB_PLACE,
    JOB_READ,
    JOB_FIXED
  } job_kind_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_ROT,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_LOOKUP,
    B_RESOLVE
  } back_state_e;

  typedef struct packed {
    rot_e               orientation;
    logic [SIZE_W-1:0]  src_width;
    logic [SIZE_W-1:0]  src_length;
    logic [PLACE_W-1:0] place_x;
    logic [PLACE_W-1:0] place_y;
    logic [PLACE_W-1:0] place_z;
  } cfg_t;

  typedef struct packed {
    job_kind_e         kind;
    status_e           status;
    logic [ADDR_W-1:0] addr;
    logic [ID_W-1:0]   key;
    logic [ID_W-1:0]   value;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== design/rvbp_front.sv =====
module rvbp_front #(
  parameter int DST_WIDTH  = 64,
  parameter int DST_HEIGHT = 16,
  parameter int DST_LENGTH = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rvbp_pkg::cfg_t                  cfg_i,
  input  logic                            clearing_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      opcode_i,
  input  logic [rvbp_pkg::SRC_IDX_W-1:0]  src_index_i,
  input  logic [rvbp_pkg::ID_W-1:0]       block_id_i,
  input  logic [rvbp_pkg::ID_W-1:0]       map_value_i,
  input  logic [rvbp_pkg::ADDR_W-1:0]     cell_address_i,
  output logic                            push_o,
  output rvbp_pkg::job_t                  push_data_o,
  input  rvbp_pkg::queue_status_t         q_status_i
);
  import rvbp_pkg::*;

  localparam logic [ADDR_W-1:0]  Z_STEP = ADDR_W'(DST_WIDTH);
  localparam logic [ADDR_W-1:0]  Y_STEP = ADDR_W'((DST_WIDTH * DST_LENGTH) % CELL_DEPTH);
  localparam logic [COORD_W-1:0] X_LIM  = COORD_W'(DST_WIDTH);
  localparam logic [COORD_W-1:0] Z_LIM  = COORD_W'(DST_LENGTH);
  localparam logic [Y_W-1:0]     Y_LIM  = Y_W'(DST_HEIGHT);

  front_state_e state_q, state_d;

  opcode_e             op_q;
  logic [ID_W-1:0]     bid_q;
  logic [ID_W-1:0]     mval_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [SRC_IDX_W-1:0] num_q, num_n;
  logic [REM_W-1:0]    rem_q, rem_n;
  logic [SIZE_W-1:0]   x_q;
  logic                phase_q;
  logic [STEP_W-1:0]   step_q;
  logic [COORD_W-1:0]  rx_q, rz_q, rx_d, rz_d;
  logic [Y_W-1:0]      ry_q, ry_d;

  logic                accept;
  logic                last_step;
  logic [SIZE_W-1:0]   w_eff, l_eff, divisor;
  logic [COORD_W-1:0]  xs, zs, rx_rot, rz_rot;
  logic                in_bounds;
  logic [ADDR_W-1:0]   cell_idx;

  assign accept    = in_valid_i && !in_stall_o;
  assign last_step = (step_q == STEP_W'(DIV_CYCLES - 1));

  // A source size of zero counts as one
  assign w_eff   = (cfg_i.src_width == '0) ? SIZE_W'(1) : cfg_i.src_width;
  assign l_eff   = (cfg_i.src_length == '0) ? SIZE_W'(1) : cfg_i.src_length;
  assign divisor = phase_q ? l_eff : w_eff;

  // Restoring division, DIV_BITS quotient bits per cycle
  always_comb begin
    num_n = num_q;
    rem_n = rem_q;
    for (int i = 0; i < DIV_BITS; i++) begin
      rem_n = {rem_n[REM_W-2:0], num_n[SRC_IDX_W-1]};
      num_n = {num_n[SRC_IDX_W-2:0], 1'b0};
      if (rem_n >= {1'b0, divisor}) begin
        rem_n    = rem_n - {1'b0, divisor};
        num_n[0] = 1'b1;
      end
    end
  end

  // Quarter turns about the vertical axis, then offset
  assign xs = COORD_W'(x_q);
  assign zs = COORD_W'(rem_q[SIZE_W-1:0]);

  always_comb begin
    unique case (cfg_i.orientation)
      ROT_NONE: begin
        rx_rot = xs;
        rz_rot = zs;
      end
      ROT_ONE: begin
        rx_rot = ~zs;
        rz_rot = xs;
      end
      ROT_TWO: begin
        rx_rot = ~xs;
        rz_rot = ~zs;
      end
      ROT_THREE: begin
        rx_rot = zs;
        rz_rot = ~xs;
      end
      default: begin
        rx_rot = xs;
        rz_rot = zs;
      end
    endcase
  end

  assign rx_d = rx_rot + COORD_W'(cfg_i.place_x);
  assign rz_d = rz_rot + COORD_W'(cfg_i.place_z);
  assign ry_d = Y_W'(num_q) + Y_W'(cfg_i.place_y);

  assign in_bounds = !rx_q[COORD_W-1] && (rx_q < X_LIM) &&
                     !rz_q[COORD_W-1] && (rz_q < Z_LIM) &&
                     (ry_q < Y_LIM);

  assign cell_idx = ADDR_W'(rx_q) + ry_q[ADDR_W-1:0] * Y_STEP + ADDR_W'(rz_q) * Z_STEP;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          state_d = (opcode_e'(opcode_i) == OP_PLACE) ? F_DIV : F_PUSH;
        end
      end
      F_DIV: begin
        if (last_step && phase_q) begin
          state_d = F_ROT;
        end
      end
      F_ROT:  state_d = F_PUSH;
      F_PUSH: begin
        if (!q_status_i.full) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall_o  = (state_q != F_IDLE) || clearing_i;
    push_o      = (state_q == F_PUSH) && !q_status_i.full;
    push_data_o = '{kind: JOB_FIXED, status: ST_OK, addr: '0, key: bid_q, value: '0};
    unique case (op_q)
      OP_LOAD: begin
        push_data_o.kind  = JOB_LOAD;
        push_data_o.value = mval_q;
      end
      OP_PLACE: begin
        if (in_bounds) begin
          push_data_o.kind = JOB_PLACE;
          push_data_o.addr = cell_idx;
        end else begin
          push_data_o.status = ST_OOB;
        end
      end
      OP_READ: begin
        push_data_o.kind = JOB_READ;
        push_data_o.addr = addr_q;
      end
      OP_NOP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      phase_q <= 1'b0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        phase_q <= 1'b0;
        step_q  <= '0;
      end else if (state_q == F_DIV) begin
        step_q <= last_step ? '0 : step_q + 1'b1;
        if (last_step) begin
          phase_q <= ~phase_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= opcode_e'(opcode_i);
      bid_q  <= block_id_i;
      mval_q <= map_value_i;
      addr_q <= cell_address_i;
      num_q  <= src_index_i;
      rem_q  <= '0;
    end else if (state_q == F_DIV) begin
      num_q <= num_n;
      if (last_step && !phase_q) begin
        // hold x, restart the remainder for the split by length
        x_q   <= rem_n[SIZE_W-1:0];
        rem_q <= '0;
      end else begin
        rem_q <= rem_n;
      end
    end
    if (state_q == F_ROT) begin
      rx_q <= rx_d;
      rz_q <= rz_d;
      ry_q <= ry_d;
    end
  end

endmodule

// ===== design/rvbp_queue.sv =====
module rvbp_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  rvbp_pkg::job_t          push_data_i,
  input  logic                    pop_i,
  output rvbp_pkg::job_t          pop_data_o,
  output rvbp_pkg::queue_status_t status_o
);
  import rvbp_pkg::*;

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;

  function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
    ptr_next = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign status_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign pop_data_o     = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= ptr_next(wptr_q);
      end
      if (pop_i) begin
        rptr_q <= ptr_next(rptr_q);
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// ===== design/rvbp_back.sv =====
module rvbp_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rvbp_pkg::queue_status_t      q_status_i,
  input  rvbp_pkg::job_t               pop_data_i,
  output logic                         pop_o,
  output logic                         clearing_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [rvbp_pkg::ADDR_W-1:0]  cell_index_o,
  output logic [rvbp_pkg::ID_W-1:0]    cell_value_o
);
  import rvbp_pkg::*;

  back_state_e state_q, state_d;

  logic [ID_W-1:0]   cell_mem [CELL_DEPTH];
  logic [ID_W-1:0]   tbl_mem  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] tbl_vld_q;

  job_t              job_q;
  logic [ADDR_W-1:0] clr_q;
  logic [ID_W-1:0]   cell_rd_q;
  logic [ID_W-1:0]   tbl_rd_q;
  logic [ID_W-1:0]   conv_id;

  logic              cs_we;
  logic [ADDR_W-1:0] cs_waddr;
  logic [ID_W-1:0]   cs_wdata;
  logic              tbl_we;
  logic              res_load;
  status_e           res_status;
  logic [ADDR_W-1:0] res_index;
  logic [ID_W-1:0]   res_value;

  logic              out_valid_q;
  status_e           out_status_q;
  logic [ADDR_W-1:0] out_index_q;
  logic [ID_W-1:0]   out_value_q;

  // Pass the key through where no valid conversion entry exists
  assign conv_id = tbl_vld_q[job_q.key] ? tbl_rd_q : job_q.key;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_CLEAR: begin
        if (clr_q == '1) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (pop_o) begin
          state_d = B_LOOKUP;
        end
      end
      B_LOOKUP:  state_d = B_RESOLVE;
      B_RESOLVE: state_d = B_IDLE;
      default:   state_d = B_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    pop_o      = 1'b0;
    clearing_o = 1'b0;
    cs_we      = 1'b0;
    cs_waddr   = clr_q;
    cs_wdata   = '0;
    tbl_we     = 1'b0;
    res_load   = 1'b0;
    res_status = ST_OK;
    res_index  = '0;
    res_value  = '0;
    unique case (state_q)
      B_CLEAR: begin
        clearing_o = 1'b1;
        cs_we      = 1'b1;
      end
      B_IDLE: begin
        pop_o = !q_status_i.empty && !out_valid_q;
      end
      B_LOOKUP: ;
      B_RESOLVE: begin
        res_load = 1'b1;
        unique case (job_q.kind)
          JOB_LOAD: begin
            tbl_we    = 1'b1;
            res_value = job_q.value;
          end
          JOB_PLACE: begin
            res_index = job_q.addr;
            if (cell_rd_q != '0) begin
              res_status = ST_OCCUPIED;
              res_value  = cell_rd_q;
            end else begin
              cs_we     = 1'b1;
              cs_waddr  = job_q.addr;
              cs_wdata  = conv_id;
              res_value = conv_id;
            end
          end
          JOB_READ: begin
            res_index = job_q.addr;
            res_value = cell_rd_q;
          end
          JOB_FIXED: begin
            res_status = job_q.status;
            res_index  = job_q.addr;
            res_value  = job_q.value;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      tbl_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (tbl_we) begin
        tbl_vld_q[job_q.key] <= 1'b1;
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= pop_data_i;
    end
    if (res_load) begin
      out_status_q <= res_status;
      out_index_q  <= res_index;
      out_value_q  <= res_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cs_we) begin
      cell_mem[cs_waddr] <= cs_wdata;
    end
    cell_rd_q <= cell_mem[job_q.addr];
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[job_q.key] <= job_q.value;
    end
    tbl_rd_q <= tbl_mem[job_q.key];
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign cell_index_o = out_index_q;
  assign cell_value_o = out_value_q;

endmodule

// ===== design/rotated_voxel_block_placer_top.sv =====
// Channel  | Handshake              | Payload
// ---------+------------------------+---------------------------------------------------
// input    | in_valid_i / in_stall_o | opcode_i, src_index_i, block_id_i, map_value_i,
//          |                        | cell_address_i
// result   | out_valid_o / out_stall_i | status_o, cell_index_o, cell_value_o
// config   | cfg_we_i (no wait)     | cfg_index_i, cfg_data_i
//
// A place transaction goes through the front in order: accept, the shared restoring
// divider (two quotient bits a cycle, first splitting off x by the source width, then
// z and y by the source length), rotate and offset, and push, which waits while the
// queue is full. Load, read and unused opcodes go from accept straight to push. The back
// takes each transaction through pop, memory lookup and resolve, and pops the next one
// only once the result register has emptied; a stalled result holds it off.
// After reset the back sweeps the 65536-entry cell store to zero, one entry a cycle;
// in_stall_o stays high throughout the sweep. Config writes are taken at all times.
// A two-entry queue parts front and back; it lets the front keep accepting while a
// result waits on out_stall_i, until the queue fills.
module rotated_voxel_block_placer_top #(
  parameter int DST_WIDTH  = 64,
  parameter int DST_HEIGHT = 16,
  parameter int DST_LENGTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [rvbp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rvbp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        opcode_i,
  input  logic [rvbp_pkg::SRC_IDX_W-1:0]    src_index_i,
  input  logic [rvbp_pkg::ID_W-1:0]         block_id_i,
  input  logic [rvbp_pkg::ID_W-1:0]         map_value_i,
  input  logic [rvbp_pkg::ADDR_W-1:0]       cell_address_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        status_o,
  output logic [rvbp_pkg::ADDR_W-1:0]       cell_index_o,
  output logic [rvbp_pkg::ID_W-1:0]         cell_value_o
);
  import rvbp_pkg::*;

  cfg_t          cfg_q;
  job_t          push_data, pop_data;
  logic          push, pop;
  logic          clearing;
  queue_status_t q_status;

  // Configuration registers; indexes past the last register are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.orientation <= ROT_NONE;
      cfg_q.src_width   <= SIZE_W'(1);
      cfg_q.src_length  <= SIZE_W'(1);
      cfg_q.place_x     <= '0;
      cfg_q.place_y     <= '0;
      cfg_q.place_z     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ORIENTATION: cfg_q.orientation <= rot_e'(cfg_data_i[1:0]);
        CFG_SRC_WIDTH:   cfg_q.src_width   <= cfg_data_i[SIZE_W-1:0];
        CFG_SRC_LENGTH:  cfg_q.src_length  <= cfg_data_i[SIZE_W-1:0];
        CFG_PLACE_X:     cfg_q.place_x     <= cfg_data_i;
        CFG_PLACE_Y:     cfg_q.place_y     <= cfg_data_i;
        CFG_PLACE_Z:     cfg_q.place_z     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front: accept, split the source index, rotate, bounds-check, classify
  rvbp_front #(
    .DST_WIDTH  (DST_WIDTH),
    .DST_HEIGHT (DST_HEIGHT),
    .DST_LENGTH (DST_LENGTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .clearing_i     (clearing),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .src_index_i    (src_index_i),
    .block_id_i     (block_id_i),
    .map_value_i    (map_value_i),
    .cell_address_i (cell_address_i),
    .push_o         (push),
    .push_data_o    (push_data),
    .q_status_i     (q_status)
  );

  // Hold classified transactions between front and back
  rvbp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  // Back: conversion table, cell store, result register
  rvbp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_status_i   (q_status),
    .pop_data_i   (pop_data),
    .pop_o        (pop),
    .clearing_o   (clearing),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .cell_index_o (cell_index_o),
    .cell_value_o (cell_value_o)
  );

endmodule

// ===== design/rvbp_checker.sv =====
module rvbp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [1:0]                      status_o,
  input logic [rvbp_pkg::ADDR_W-1:0]     cell_index_o,
  input logic [rvbp_pkg::ID_W-1:0]       cell_value_o
);
  import rvbp_pkg::*;

  logic [3:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Count transactions accepted but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 4'(in_acc) - 4'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(cell_index_o) && $stable(cell_value_o))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 4'd0)
    else $error("result without an accepted transaction");

  a_oob_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OOB |-> cell_index_o == '0 && cell_value_o == '0)
    else $error("out-of-bounds result carries index or value");

  a_occupied_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OCCUPIED |-> cell_value_o != '0)
    else $error("occupied result shows an empty cell");

endmodule

bind rotated_voxel_block_placer_top rvbp_checker u_rvbp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .cell_index_o (cell_index_o),
  .cell_value_o (cell_value_o)
);

// ===== bench/rotated_voxel_block_placer_top_tb.sv =====
module rotated_voxel_block_placer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rvbp_pkg::*;

  // Destination grid of the instance under test
  localparam int DST_W = 64;
  localparam int DST_H = 16;
  localparam int DST_L = 64;

  // Cycles without any transaction before the run is declared hung. The cell
  // store sweep after reset alone keeps the input stalled while it clears all 65536 entries.
  localparam int HANG_LIMIT = 200000;

  typedef enum {
    PACE_NONE,
    PACE_SENDER,
    PACE_RECEIVER,
    PACE_BOTH
  } pace_e;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] index;
    logic [ID_W-1:0]   value;
  } cell_outcome_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           opcode_i = '0;
  logic [SRC_IDX_W-1:0] src_index_i = '0;
  logic [ID_W-1:0]      block_id_i = '0;
  logic [ID_W-1:0]      map_value_i = '0;
  logic [ADDR_W-1:0]    cell_address_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [1:0]           status_o;
  logic [ADDR_W-1:0]    cell_index_o;
  logic [ID_W-1:0]      cell_value_o;

  // Mirror of the block's state: destination cells and the id conversion table
  // (bit 8 marks a loaded entry). Two-state arrays start out all zero.
  bit [ID_W-1:0]   cell_image [CELL_DEPTH];
  bit [ID_W:0]     remap_table [TABLE_DEPTH];
  rot_e            turns = ROT_NONE;
  logic [SIZE_W-1:0]  span_x = 11'd1;
  logic [SIZE_W-1:0]  span_z = 11'd1;
  logic [PLACE_W-1:0] offset_x = '0;
  logic [PLACE_W-1:0] offset_y = '0;
  logic [PLACE_W-1:0] offset_z = '0;

  cell_outcome_t     expected_outcomes [$];
  logic [ADDR_W-1:0] filled_cells [$];

  int mismatches = 0;
  int n_loads = 0;
  int n_places = 0;
  int n_oob = 0;
  int n_occupied = 0;
  int n_reads = 0;
  int n_spare = 0;
  int n_results = 0;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_request = 0;
  int quiet_cycles = 0;

  rotated_voxel_block_placer_top #(
    .DST_WIDTH (DST_W),
    .DST_HEIGHT(DST_H),
    .DST_LENGTH(DST_L)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .src_index_i   (src_index_i),
    .block_id_i    (block_id_i),
    .map_value_i   (map_value_i),
    .cell_address_i(cell_address_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .cell_index_o  (cell_index_o),
    .cell_value_o  (cell_value_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Work out the result of one accepted transaction and update the mirrored
  // state exactly as the block must.
  function automatic cell_outcome_t placement_outcome(opcode_e op, logic [SRC_IDX_W-1:0] src,
                                                      logic [ID_W-1:0] key,
                                                      logic [ID_W-1:0] mapped,
                                                      logic [ADDR_W-1:0] addr);
    cell_outcome_t r;
    int w, l, area, plane, x, y, z, t;
    logic [ADDR_W-1:0] idx;
    r.status = ST_OK;
    r.index  = '0;
    r.value  = '0;
    case (op)
      OP_LOAD: begin
        remap_table[key] = {1'b1, mapped};
        r.value = mapped;
        n_loads++;
      end
      OP_PLACE: begin
        n_places++;
        // a zero source size behaves as one
        w = (span_x == 0) ? 1 : int'(span_x);
        l = (span_z == 0) ? 1 : int'(span_z);
        area  = w * l;
        plane = int'(src) % area;
        x = plane % w;
        z = plane / w;
        y = int'(src) / area;
        case (turns)
          ROT_ONE: begin
            t = x;
            x = -z - 1;
            z = t;
          end
          ROT_TWO: begin
            x = -x - 1;
            z = -z - 1;
          end
          ROT_THREE: begin
            t = x;
            x = z;
            z = -t - 1;
          end
          default: ;
        endcase
        x += int'(offset_x);
        y += int'(offset_y);
        z += int'(offset_z);
        if (x < 0 || x >= DST_W || y < 0 || y >= DST_H || z < 0 || z >= DST_L) begin
          r.status = ST_OOB;
          n_oob++;
        end else begin
          idx = ADDR_W'(x + y * DST_W * DST_L + z * DST_W);
          r.index = idx;
          if (cell_image[idx] != 0) begin
            r.status = ST_OCCUPIED;
            r.value  = cell_image[idx];
            n_occupied++;
          end else begin
            // remap through a loaded entry, else pass the id through; id zero
            // leaves the cell empty
            r.value = remap_table[key][ID_W] ? remap_table[key][ID_W-1:0] : key;
            cell_image[idx] = r.value;
            if (r.value != 0) filled_cells = {filled_cells, idx};
          end
        end
      end
      OP_READ: begin
        r.index = addr;
        r.value = cell_image[addr];
        n_reads++;
      end
      default: n_spare++;
    endcase
    return r;
  endfunction

  // Predict on every accepted input transaction, check every accepted result
  // against the oldest prediction, and watch for a hung block.
  always @(posedge clk_i) begin : result_checker
    cell_outcome_t want;
    logic in_fire, out_fire;
    in_fire  = rst_ni && in_valid_i && !in_stall_o;
    out_fire = rst_ni && out_valid_o && !out_stall_i;
    if (out_fire) begin
      n_results++;
      if (expected_outcomes.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: status %0d index %0h value %0h",
                                  status_o, cell_index_o, cell_value_o));
      end else begin
        want = expected_outcomes.pop_front();
        if (status_o !== want.status)
          report_mismatch($sformatf("status: got %0d, expected %0d", status_o, want.status));
        if (cell_index_o !== want.index)
          report_mismatch($sformatf("cell_index: got %0h, expected %0h",
                                    cell_index_o, want.index));
        if (cell_value_o !== want.value)
          report_mismatch($sformatf("cell_value: got %0h, expected %0h",
                                    cell_value_o, want.value));
      end
    end
    if (in_fire)
      expected_outcomes = {expected_outcomes,
                           placement_outcome(opcode_e'(opcode_i), src_index_i,
                                             block_id_i, map_value_i, cell_address_i)};
    if (in_fire || out_fire || !rst_ni) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("TIMEOUT: no transaction for %0d cycles, %0d results pending",
               HANG_LIMIT, expected_outcomes.size());
      $display("** rotated_voxel_block_placer_top: FAILED **");
      $finish;
    end
  end

  // Result side: stall at the current pace, or hold off for a requested stretch.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
    end
  end

  task automatic set_pace(pace_e pace);
    sender_idle_pct    = (pace == PACE_SENDER) ? 84 : (pace == PACE_BOTH) ? 11 : 0;
    receiver_stall_pct = (pace == PACE_RECEIVER) ? 84 : (pace == PACE_BOTH) ? 11 : 0;
  endtask

  // Offer one transaction and hold it until accepted. Call at a rising edge;
  // returns at the edge of acceptance with valid still high.
  task automatic send_item(opcode_e op, logic [SRC_IDX_W-1:0] src, logic [ID_W-1:0] key,
                           logic [ID_W-1:0] mapped, logic [ADDR_W-1:0] addr);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    src_index_i    <= src;
    block_id_i     <= key;
    map_value_i    <= mapped;
    cell_address_i <= addr;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid and wait for every pending result.
  task automatic wait_until_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_outcomes.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic put_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
  endtask

  // Write all six registers; only call with nothing in flight.
  task automatic apply_setup(rot_e rot, logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] l,
                             logic [PLACE_W-1:0] px, logic [PLACE_W-1:0] py,
                             logic [PLACE_W-1:0] pz);
    turns    = rot;
    span_x   = w;
    span_z   = l;
    offset_x = px;
    offset_y = py;
    offset_z = pz;
    put_reg(CFG_ORIENTATION, CFG_DATA_W'(rot));
    put_reg(CFG_SRC_WIDTH, CFG_DATA_W'(w));
    put_reg(CFG_SRC_LENGTH, CFG_DATA_W'(l));
    put_reg(CFG_PLACE_X, px);
    put_reg(CFG_PLACE_Y, py);
    put_reg(CFG_PLACE_Z, pz);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_conversion_and_occupancy();
    apply_setup(ROT_NONE, 11'd4, 11'd4, 12'd0, 12'd0, 12'd0);
    send_item(OP_LOAD, '0, 8'd5, 8'd77, '0);           // key 5 -> 77
    send_item(OP_PLACE, 20'd0, 8'd5, '0, '0);          // remapped id lands in cell 0
    send_item(OP_PLACE, 20'd1, 8'd9, '0, '0);          // no entry: id passes through
    send_item(OP_PLACE, 20'd0, 8'd1, '0, '0);          // cell 0 already occupied
    send_item(OP_PLACE, 20'd2, 8'd0, '0, '0);          // id zero leaves the cell empty
    send_item(OP_PLACE, 20'd2, 8'd3, '0, '0);          // so this one still goes in
    send_item(OP_READ, '0, '0, '0, 16'h0000);
    send_item(OP_READ, '0, '0, '0, 16'h0002);
    send_item(OP_READ, '0, '0, '0, 16'hFFFF);
    send_item(OP_NOP, 20'hFFFFF, 8'hFF, 8'hFF, 16'hFFFF);
    send_item(OP_PLACE, 20'hFFFFF, 8'hFF, '0, '0);     // y far beyond the grid
    send_item(OP_LOAD, '0, 8'hFF, 8'hFF, '0);
    send_item(OP_PLACE, 20'd3, 8'hFF, '0, '0);
    wait_until_idle();
  endtask

  task automatic test_rotations();
    rot_e rot;
    rot = ROT_NONE;
    // centre the source so every turn stays inside the grid
    do begin
      apply_setup(rot, 11'd4, 11'd3, 12'd32, 12'd3, 12'd32);
      send_item(OP_PLACE, 20'd0, 8'h11, '0, '0);
      send_item(OP_PLACE, 20'd11, 8'h22, '0, '0);
      wait_until_idle();
      rot = rot.next();
    end while (rot != ROT_NONE);
  endtask

  task automatic test_size_extremes();
    apply_setup(ROT_NONE, 11'd0, 11'd0, 12'd10, 12'd0, 12'd10);
    send_item(OP_PLACE, 20'd7, 8'd1, '0, '0);          // zero sizes act as one
    wait_until_idle();
    apply_setup(ROT_TWO, 11'd1024, 11'd1024, 12'd0, 12'd0, 12'd0);
    send_item(OP_PLACE, 20'd0, 8'd2, '0, '0);          // goes negative after the turn
    send_item(OP_PLACE, 20'hFFFFF, 8'd2, '0, '0);
    wait_until_idle();
    apply_setup(ROT_NONE, 11'd1024, 11'd1024, 12'hFFF, 12'hFFF, 12'hFFF);
    send_item(OP_PLACE, 20'd0, 8'd2, '0, '0);
    wait_until_idle();
  endtask

  function automatic logic [SIZE_W-1:0] draw_size();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return 11'd1024;
    if (pick == 2) return SIZE_W'($urandom_range(1, 1024));
    return SIZE_W'($urandom_range(1, 12));
  endfunction

  function automatic logic [PLACE_W-1:0] draw_offset(int reach);
    if ($urandom_range(0, 19) == 0) return PLACE_W'($urandom_range(0, 4095));
    return PLACE_W'($urandom_range(0, reach - 1));
  endfunction

  task automatic send_random_item();
    int pick, span;
    opcode_e op;
    logic [SRC_IDX_W-1:0] src;
    logic [ADDR_W-1:0] addr;
    pick = $urandom_range(0, 99);
    op = (pick < 10) ? OP_LOAD : (pick < 75) ? OP_PLACE : (pick < 95) ? OP_READ : OP_NOP;
    // keep most indices within a few layers so targets land and collide
    span = ((span_x == 0) ? 1 : int'(span_x)) * ((span_z == 0) ? 1 : int'(span_z)) * 8;
    if (span > (1 << SRC_IDX_W)) span = 1 << SRC_IDX_W;
    if ($urandom_range(0, 6) == 0) src = SRC_IDX_W'($urandom_range(0, 20'hFFFFF));
    else src = SRC_IDX_W'($urandom_range(0, span - 1));
    if (filled_cells.size() > 0 && $urandom_range(0, 1))
      addr = filled_cells[$urandom_range(0, filled_cells.size() - 1)];
    else
      addr = ADDR_W'($urandom_range(0, 16'hFFFF));
    send_item(op, src, ID_W'($urandom_range(0, 255)), ID_W'($urandom_range(0, 255)), addr);
  endtask

  task automatic apply_random_setup();
    rot_e rot;
    logic [SIZE_W-1:0] w, l;
    logic [PLACE_W-1:0] px, py, pz;
    rot = rot_e'($urandom_range(0, 3));
    w   = draw_size();
    l   = draw_size();
    px  = draw_offset(DST_W);
    py  = draw_offset(DST_H);
    pz  = draw_offset(DST_L);
    apply_setup(rot, w, l, px, py, pz);
  endtask

  // Hold the result side off for a long stretch while items keep coming, so
  // the queue fills and the input stalls; then pause until all has drained.
  task automatic test_backpressure();
    set_pace(PACE_NONE);
    apply_setup(ROT_ONE, 11'd5, 11'd6, 12'd20, 12'd2, 12'd9);
    hold_request = 400;
    repeat (40) send_random_item();
    wait_until_idle();
  endtask

  task automatic test_random_traffic(pace_e pace, int setups, int per_setup);
    set_pace(pace);
    repeat (setups) begin
      apply_random_setup();
      repeat (per_setup) send_random_item();
      wait_until_idle();
    end
    set_pace(PACE_NONE);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_conversion_and_occupancy();
    test_rotations();
    test_size_extremes();
    test_backpressure();
    test_random_traffic(PACE_NONE, 4, 62);
    test_random_traffic(PACE_SENDER, 4, 62);
    test_random_traffic(PACE_RECEIVER, 4, 62);
    test_random_traffic(PACE_BOTH, 4, 62);

    // let any stray result show up before judging
    repeat (60) @(posedge clk_i);
    if (expected_outcomes.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_outcomes.size()));

    $display("Covered %0d loads, %0d places (%0d out of bounds, %0d occupied), %0d reads,",
             n_loads, n_places, n_oob, n_occupied, n_reads);
    $display("%0d spare opcodes and %0d checked results over four rotations and four paces",
             n_spare, n_results);
    if (mismatches == 0) begin
      $display("** rotated_voxel_block_placer_top: PASSED **");
    end else begin
      $display("** rotated_voxel_block_placer_top: FAILED **");
    end
    $finish;
  end

endmodule
